[rtl/core/bmp_pkg.sv]
// ----------------------------------------------------------------------------
// Boolean matrix product package
// Shared widths, request codes, register indexes and the control and status
// structs that link the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bmp_pkg;

  // Field widths fixed by the request and result formats.
  localparam int FUNC_W    = 2;
  localparam int IDX_W     = 3;
  localparam int ROW_W     = 8;
  localparam int DIM_W     = 4;
  localparam int CFG_IDX_W = 2;

  // Request function codes.
  localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic emit;
  } bmp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_space;
    logic last;
  } bmp_sts_t;

endpackage

`default_nettype wire

[rtl/core/bmp_if.sv]
// ----------------------------------------------------------------------------
// Boolean matrix product channels
// Request channel (loads and compute) and result channel (one product row).
// ----------------------------------------------------------------------------
`default_nettype none

interface bmp_in_if;
  import bmp_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [IDX_W-1:0]  row_index;
  logic [IDX_W-1:0]  col_index;
  logic              bit_value;

  modport source (output valid, output func, output row_index, output col_index,
                  output bit_value, input ready);
  modport sink   (input valid, input func, input row_index, input col_index,
                  input bit_value, output ready);
endinterface

interface bmp_out_if;
  import bmp_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] out_row;
  logic [ROW_W-1:0] row_bits;
  logic             last_row;

  modport source (output valid, output out_row, output row_bits, output last_row,
                  input ready);
  modport sink   (input valid, input out_row, input row_bits, input last_row,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/bmp_ctrl.sv]
// ----------------------------------------------------------------------------
// Boolean matrix product controller
// Decodes requests into datapath commands and sequences the product rows.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic [bmp_pkg::FUNC_W-1:0] func_i,
  output logic                           in_ready_o,
  input  wire bmp_pkg::bmp_sts_t         sts_i,
  output bmp_pkg::bmp_cmd_t              cmd_o
);
  import bmp_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic state_q, state_d;
  logic accept;

  // Requests are taken only while no product is being walked.
  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  // Command decode.
  always_comb begin
    cmd_o        = '0;
    cmd_o.load_a = accept && (func_i == FUNC_LOAD_A);
    cmd_o.load_b = accept && (func_i == FUNC_LOAD_B);
    cmd_o.start  = accept && (func_i == FUNC_COMPUTE);
    cmd_o.emit   = (state_q == StRun) && sts_i.out_space;
  end

  // Next state: run until the final row has been placed in the output register.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_o.start) state_d = StRun;
      end
      StRun: begin
        if (cmd_o.emit && sts_i.last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bmp_dp.sv]
// ----------------------------------------------------------------------------
// Boolean matrix product datapath
// Holds both matrices, the dimension registers, the row counter and the
// result register, and forms one product row per emit command.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_dp #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bmp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [bmp_pkg::DIM_W-1:0]     cfg_data_i,
  input  wire logic [bmp_pkg::IDX_W-1:0]     row_index_i,
  input  wire logic [bmp_pkg::IDX_W-1:0]     col_index_i,
  input  wire logic                         bit_value_i,
  input  wire bmp_pkg::bmp_cmd_t            cmd_i,
  output bmp_pkg::bmp_sts_t                 sts_o,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic [bmp_pkg::IDX_W-1:0]          out_row_o,
  output logic [bmp_pkg::ROW_W-1:0]          row_bits_o,
  output logic                              last_row_o
);
  import bmp_pkg::*;

  localparam logic [DIM_W-1:0] MaxDimV = DIM_W'(MAX_DIM);

  logic [DIM_W-1:0] row_cnt_q, inner_cnt_q, col_cnt_q;
  logic [DIM_W-1:0] rows_c, inner_c, cols_c;
  logic [ROW_W-1:0] a_q [MAX_DIM];
  logic [ROW_W-1:0] b_q [MAX_DIM];
  logic [IDX_W-1:0] idx_q;
  logic [ROW_W-1:0] a_row;
  logic [ROW_W-1:0] prod;
  logic             last;
  logic             out_valid_q;
  logic [IDX_W-1:0] out_row_q;
  logic [ROW_W-1:0] row_bits_q;
  logic             last_row_q;

  // Dimension registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q   <= DIM_W'(1);
      inner_cnt_q <= DIM_W'(1);
      col_cnt_q   <= DIM_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROW_COUNT:   row_cnt_q   <= cfg_data_i;
        CFG_INNER_COUNT: inner_cnt_q <= cfg_data_i;
        CFG_COL_COUNT:   col_cnt_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero dimension counts as one; anything above the maximum saturates.
  always_comb begin
    rows_c  = (row_cnt_q == '0) ? DIM_W'(1) : (row_cnt_q > MaxDimV) ? MaxDimV : row_cnt_q;
    inner_c = (inner_cnt_q == '0) ? DIM_W'(1)
            : (inner_cnt_q > MaxDimV) ? MaxDimV : inner_cnt_q;
    cols_c  = (col_cnt_q == '0) ? DIM_W'(1) : (col_cnt_q > MaxDimV) ? MaxDimV : col_cnt_q;
  end

  // Matrix storage: each load writes a single bit in place.
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < MAX_DIM; r++) begin
      for (int c = 0; c < MAX_DIM; c++) begin
        if (row_index_i == IDX_W'(r) && col_index_i == IDX_W'(c)) begin
          if (cmd_i.load_a) a_q[r][c] <= bit_value_i;
          if (cmd_i.load_b) b_q[r][c] <= bit_value_i;
        end
      end
    end
  end

  // Select the current row of the first matrix.
  always_comb begin
    a_row = '0;
    for (int r = 0; r < MAX_DIM; r++) begin
      if (idx_q == IDX_W'(r)) a_row = a_q[r];
    end
  end

  // One product row: OR of the second-matrix rows picked by the first-matrix row.
  always_comb begin
    prod = '0;
    for (int k = 0; k < MAX_DIM; k++) begin
      if (a_row[k] && (DIM_W'(k) < inner_c)) prod = prod | b_q[k];
    end
    for (int j = 0; j < ROW_W; j++) begin
      if (DIM_W'(j) >= cols_c) prod[j] = 1'b0;
    end
  end

  assign last = (({1'b0, idx_q} + DIM_W'(1)) == rows_c);

  // Row counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.start) begin
      idx_q <= '0;
    end else if (cmd_i.emit) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_row_q  <= idx_q;
      row_bits_q <= prod;
      last_row_q <= last;
    end
  end

  assign sts_o.out_space = !out_valid_q || out_ready_i;
  assign sts_o.last      = last;

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign row_bits_o  = row_bits_q;
  assign last_row_o  = last_row_q;

endmodule

`default_nettype wire

[rtl/core/boolean_matrix_product.sv]
// ----------------------------------------------------------------------------
// Boolean matrix product engine
// Loads two bit matrices one element at a time and emits their OR-of-AND
// product one row per result.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel in_if carries func, row_index, col_index and bit_value.
//   A load of either matrix produces no result, so loads can stream at one
//   per cycle while no compute is in progress. A compute request walks the
//   product rows from row 0, one row per cycle through the result register
//   while the receiver does not stall, and marks the final row with last_row.
//   While a compute is in progress the request channel is not ready; it opens
//   again once the final row is registered. Acceptance moves the controller to
//   its run state; the first row is then registered. A receiver stall holds
//   the current row in the result register and pauses the row walk. Dimensions
//   are to be written on the cfg port only while idle; the block does not
//   enforce this. Reset sets all three dimensions to one and empties the
//   result register; matrix contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module boolean_matrix_product #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bmp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [bmp_pkg::DIM_W-1:0]     cfg_data_i,
  bmp_in_if.sink                            in_if,
  bmp_out_if.source                         out_if
);
  import bmp_pkg::*;

  bmp_cmd_t cmd;
  bmp_sts_t sts;

  // Controller.
  bmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .func_i     (in_if.func),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath.
  bmp_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .row_index_i (in_if.row_index),
    .col_index_i (in_if.col_index),
    .bit_value_i (in_if.bit_value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .out_row_o   (out_if.out_row),
    .row_bits_o  (out_if.row_bits),
    .last_row_o  (out_if.last_row)
  );

endmodule

`default_nettype wire

[rtl/core/bmp_checker.sv]
// ----------------------------------------------------------------------------
// Boolean matrix product port checker
// Checks the row sequencing and request gating seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic [bmp_pkg::FUNC_W-1:0] in_func,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [bmp_pkg::IDX_W-1:0]  out_row,
  input wire logic [bmp_pkg::ROW_W-1:0]  row_bits,
  input wire logic                      last_row
);
  import bmp_pkg::*;

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(row_bits)
      && $stable(last_row))
    else $error("stalled result changed");

  // A taken non-final row is followed at once by the next row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !last_row
      |=> out_valid && (out_row == IDX_W'($past(out_row) + IDX_W'(1))))
    else $error("product rows not in sequence");

  // No request is taken while a non-final row is shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !last_row |-> !in_ready)
    else $error("request channel open during a compute");

  // A compute request closes the request channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_func == FUNC_COMPUTE) |=> !in_ready)
    else $error("compute did not close the request channel");

endmodule

bind boolean_matrix_product bmp_checker u_bmp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_func   (in_if.func),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_row   (out_if.out_row),
  .row_bits  (out_if.row_bits),
  .last_row  (out_if.last_row)
);

`default_nettype wire

[tb/bmp_product_check.sv]
// ----------------------------------------------------------------------------
// Boolean matrix product checker
// Watches the register port and both channels, keeps its own copy of the two
// bit matrices and the dimensions, works out the product rows that each
// compute request should yield, and compares every returned row against the
// oldest outstanding row, field by field.
// ----------------------------------------------------------------------------
module bmp_product_check
  import bmp_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  bmp_in_if                    in_if,
  bmp_out_if                   out_if,
  output int                   fail_count_o,
  output int                   pending_o
);

  // Maximum number of mismatch lines printed; later ones are only counted.
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [IDX_W-1:0] row_idx;
    logic [ROW_W-1:0] bits;
    logic             last_row;
  } product_row_t;

  // Local copy of both matrices (row-major, one bit per column).
  logic [MAX_DIM-1:0] first_rows  [MAX_DIM];
  logic [MAX_DIM-1:0] second_rows [MAX_DIM];
  logic [DIM_W-1:0]   row_reg;
  logic [DIM_W-1:0]   inner_reg;
  logic [DIM_W-1:0]   col_reg;

  product_row_t expected_rows [$];
  product_row_t want;

  initial fail_count_o = 0;

  // A dimension of zero counts as one; anything above the maximum saturates.
  function automatic int unsigned dim_of(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Queue up the rows of the OR-of-ANDs product for the current dimensions.
  function automatic void predict_product();
    int unsigned  n_rows;
    int unsigned  n_inner;
    int unsigned  n_cols;
    product_row_t p;
    n_rows  = dim_of(row_reg);
    n_inner = dim_of(inner_reg);
    n_cols  = dim_of(col_reg);
    for (int unsigned i = 0; i < n_rows; i++) begin
      p.bits = '0;
      for (int unsigned j = 0; j < n_cols; j++) begin
        for (int unsigned k = 0; k < n_inner; k++) begin
          if (first_rows[i][k] && second_rows[k][j]) p.bits[j] = 1'b1;
        end
      end
      p.row_idx  = i[IDX_W-1:0];
      p.last_row = (i + 1 == n_rows);
      expected_rows.push_back(p);
    end
  endfunction

  task automatic report_mismatch(string what);
    if (fail_count_o < PRINT_LIMIT) $display("ERROR at %0t: %s", $time, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_reg   = DIM_W'(1);
      inner_reg = DIM_W'(1);
      col_reg   = DIM_W'(1);
      for (int i = 0; i < MAX_DIM; i++) begin
        first_rows[i]  = '0;
        second_rows[i] = '0;
      end
      expected_rows.delete();
      pending_o <= 0;
    end else begin
      // Register writes take effect for the requests that follow.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROW_COUNT:   row_reg   = cfg_data_i;
          CFG_INNER_COUNT: inner_reg = cfg_data_i;
          CFG_COL_COUNT:   col_reg   = cfg_data_i;
          default: ;
        endcase
      end

      // Accepted request: update a matrix bit or predict a whole product.
      if (in_if.valid && in_if.ready) begin
        case (in_if.func)
          FUNC_LOAD_A:  first_rows[in_if.row_index][in_if.col_index]  = in_if.bit_value;
          FUNC_LOAD_B:  second_rows[in_if.row_index][in_if.col_index] = in_if.bit_value;
          FUNC_COMPUTE: predict_product();
          default: ;
        endcase
      end

      // Accepted result: compare against the oldest outstanding row.
      if (out_if.valid && out_if.ready) begin
        if (expected_rows.size() == 0) begin
          report_mismatch($sformatf("row %0d bits %h with no product outstanding",
                                    out_if.out_row, out_if.row_bits));
        end else begin
          want = expected_rows.pop_front();
          if (out_if.out_row !== want.row_idx)
            report_mismatch($sformatf("out_row %0d, expected %0d",
                                      out_if.out_row, want.row_idx));
          if (out_if.row_bits !== want.bits)
            report_mismatch($sformatf("row %0d row_bits %h, expected %h",
                                      want.row_idx, out_if.row_bits, want.bits));
          if (out_if.last_row !== want.last_row)
            report_mismatch($sformatf("row %0d last_row %b, expected %b",
                                      want.row_idx, out_if.last_row, want.last_row));
        end
      end

      pending_o <= expected_rows.size();
    end
  end

endmodule

[tb/boolean_matrix_product_test.sv]
// ----------------------------------------------------------------------------
// Boolean matrix product testbench
// Drives loads and compute requests into the engine under several dimension
// settings and three idle profiles, holds the result channel off once to
// back the engine up, and reports the verdict from the checker's count.
// ----------------------------------------------------------------------------
module boolean_matrix_product_test;
  import bmp_pkg::*;

  localparam int MAX_DIM = 8;

  // Codes left unused by the engine; both must be ignored.
  localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 60;
  localparam int SEGMENT_ITEMS = 40;
  localparam int SEGMENTS      = 6;
  localparam int DRAIN_CYCLES  = 12;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DIM_W-1:0]     cfg_data;

  bmp_in_if  in_ch ();
  bmp_out_if out_ch ();

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int ones_pct      = 50;
  int hold_asked    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int stall_cycles  = 0;

  // Which matrix bits have been loaded, and the effective dimensions.
  logic [MAX_DIM-1:0] written_a [MAX_DIM];
  logic [MAX_DIM-1:0] written_b [MAX_DIM];
  int unsigned        dim_rows  = 1;
  int unsigned        dim_inner = 1;
  int unsigned        dim_cols  = 1;

  boolean_matrix_product #(
    .MAX_DIM (MAX_DIM)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  bmp_product_check #(
    .MAX_DIM (MAX_DIM)
  ) product_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_if        (in_ch),
    .out_if       (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result receiver: random stalls, plus one long hold-off when asked.
  always @(posedge clk_i) begin
    if (hold_seen != hold_asked) begin
      hold_seen     <= hold_asked;
      hold_left     <= HOLD_CYCLES;
      out_ch.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_ch.ready  <= 1'b0;
    end else begin
      out_ch.ready  <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: ends the run when no request or result moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL boolean_matrix_product");
        $finish;
      end
    end
  end

  function automatic logic random_bit();
    return ($urandom_range(99) < ones_pct);
  endfunction

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Offer one request, idling first at random, and wait until it is taken.
  task automatic send_request(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] r,
                              logic [IDX_W-1:0] c, logic v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid     <= 1'b0;
      in_ch.func      <= FUNC_W'($urandom_range(3));
      in_ch.row_index <= IDX_W'($urandom_range(7));
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.row_index <= r;
    in_ch.col_index <= c;
    in_ch.bit_value <= v;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic load_bit(logic [FUNC_W-1:0] f, int unsigned r, int unsigned c, logic v);
    if (f == FUNC_LOAD_A) written_a[r][c] = 1'b1;
    else written_b[r][c] = 1'b1;
    send_request(f, r[IDX_W-1:0], c[IDX_W-1:0], v);
  endtask

  // Load any bit the product will read that is still unknown, then compute.
  task automatic compute_product();
    for (int unsigned i = 0; i < dim_rows; i++)
      for (int unsigned k = 0; k < dim_inner; k++)
        if (!written_a[i][k]) load_bit(FUNC_LOAD_A, i, k, random_bit());
    for (int unsigned k = 0; k < dim_inner; k++)
      for (int unsigned j = 0; j < dim_cols; j++)
        if (!written_b[k][j]) load_bit(FUNC_LOAD_B, k, j, random_bit());
    send_request(FUNC_COMPUTE, IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)),
                 random_bit());
  endtask

  // Stop offering requests and let every outstanding row come back.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all dimension registers, plus the unused index, while idle.
  task automatic set_dims(logic [DIM_W-1:0] r, logic [DIM_W-1:0] i, logic [DIM_W-1:0] c);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_ROW_COUNT;
    cfg_data <= r;
    @(posedge clk_i);
    cfg_idx  <= CFG_INNER_COUNT;
    cfg_data <= i;
    @(posedge clk_i);
    cfg_idx  <= CFG_COL_COUNT;
    cfg_data <= c;
    @(posedge clk_i);
    cfg_idx  <= CFG_UNUSED;
    cfg_data <= DIM_W'($urandom_range(15));
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    dim_rows  = clamp_dim(r);
    dim_inner = clamp_dim(i);
    dim_cols  = clamp_dim(c);
  endtask

  initial begin
    int unsigned      pick;
    int unsigned      count;
    int unsigned      r_lim;
    int unsigned      c_lim;
    logic [FUNC_W-1:0] f;

    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_LOAD_A;
    in_ch.row_index = '0;
    in_ch.col_index = '0;
    in_ch.bit_value = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_ROW_COUNT;
    cfg_data        = '0;
    for (int i = 0; i < MAX_DIM; i++) begin
      written_a[i] = '0;
      written_b[i] = '0;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Single-element product at the reset dimensions, each operand toggled.
    load_bit(FUNC_LOAD_A, 0, 0, 1'b1);
    load_bit(FUNC_LOAD_B, 0, 0, 1'b1);
    compute_product();
    send_request(FUNC_UNUSED, IDX_W'(7), IDX_W'(7), 1'b1);
    // Loads outside the current dimensions still land but are not read.
    load_bit(FUNC_LOAD_A, 7, 7, 1'b1);
    load_bit(FUNC_LOAD_B, 7, 7, 1'b1);
    load_bit(FUNC_LOAD_A, 7, 0, 1'b0);
    load_bit(FUNC_LOAD_B, 0, 7, 1'b1);
    compute_product();
    load_bit(FUNC_LOAD_B, 0, 0, 1'b0);
    compute_product();
    load_bit(FUNC_LOAD_A, 0, 0, 1'b0);
    load_bit(FUNC_LOAD_B, 0, 0, 1'b1);
    compute_product();

    // Random segments, each under its own dimensions and idle profile.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: set_dims(4'd0, 4'd0, 4'd0);
        1: set_dims(4'd15, 4'd15, 4'd15);
        2: set_dims(4'd8, 4'd8, 4'd8);
        3: set_dims(4'd3, 4'd5, 4'd2);
        4: set_dims(4'd1, 4'd8, 4'd1);
        default: set_dims(4'd8, 4'd1, 4'd9);
      endcase
      send_idle_pct = (seg < 2) ? 15 : (seg < 4) ? 60 : 0;
      recv_idle_pct = (seg < 2) ? 60 : (seg < 4) ? 15 : 0;
      ones_pct      = (seg % 3 == 0) ? 50 : (seg % 3 == 1) ? 25 : 70;

      // Back-to-back full-size products against a stalled receiver.
      if (seg == 2) begin
        compute_product();
        hold_asked <= hold_asked + 1;
        repeat (4) compute_product();
      end

      count = 0;
      while (count < SEGMENT_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          send_request(FUNC_UNUSED, IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)),
                       random_bit());
        end else begin
          count++;
          if (pick < 15) begin
            compute_product();
          end else begin
            f = (pick < 57) ? FUNC_LOAD_A : FUNC_LOAD_B;
            if (f == FUNC_LOAD_A) begin
              r_lim = dim_rows;
              c_lim = dim_inner;
            end else begin
              r_lim = dim_inner;
              c_lim = dim_cols;
            end
            if ($urandom_range(3) == 0) begin
              r_lim = MAX_DIM;
              c_lim = MAX_DIM;
            end
            load_bit(f, $urandom_range(r_lim - 1), $urandom_range(c_lim - 1), random_bit());
          end
        end
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("PASS boolean_matrix_product");
    end else begin
      $display("FAIL boolean_matrix_product");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/bmp_pkg.sv
rtl/core/bmp_if.sv
rtl/core/bmp_ctrl.sv
rtl/core/bmp_dp.sv
rtl/core/boolean_matrix_product.sv
rtl/core/bmp_checker.sv
tb/bmp_product_check.sv
tb/boolean_matrix_product_test.sv
